[design/ubx_frame_receiver_defines.svh]
// Assertion macros shared by the checker of the frame receiver.
// No dependencies; included by the assertion files only.
`ifndef UBX_FRAME_RECEIVER_DEFINES_SVH
`define UBX_FRAME_RECEIVER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define UBX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubx_frame_receiver: same-cycle check failed");

// Check that a condition implies another in the following cycle
`define UBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubx_frame_receiver: next-cycle check failed");

`endif

[design/ubx_pkg.sv]
// Shared types and constants of the UBX frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package ubx_pkg;

    // Framing constants
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam int         MAX_PAYLOAD = 128;

    // Width of the packed result bus
    localparam int TDATA_W = 56;

    // Receive phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_CLASS   = 8'b0000_0010,
        PH_ID      = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CK_A    = 8'b0100_0000,
        PH_CK_B    = 8'b1000_0000
    } ubx_phase_t;

    // One result per received byte
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
        logic        checksum_ok;
        logic        length_too_long;
    } ubx_result_t;

endpackage

`default_nettype wire

[design/ubx_parser.sv]
// Frame parser: phase register, held header fields and Fletcher sums.
// Depends on ubx_pkg.
`default_nettype none

module ubx_parser
#(
    parameter int MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           rx_byte,
    output ubx_pkg::ubx_result_t      result
);

    ubx_pkg::ubx_phase_t phase_reg, phase_next;
    logic        sync_seen_reg, sync_seen_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  held_class_reg, held_class_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  first_check_reg, first_check_next;

    logic [7:0]  sum_a_base;
    logic [7:0]  sum_b_base;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [7:0]  byte_count_inc;
    logic [15:0] length_full;

    // Fletcher step; the class byte restarts both sums
    always_comb
    begin
        sum_a_base = (phase_reg == ubx_pkg::PH_CLASS) ? 8'd0 : sum_a_reg;
        sum_b_base = (phase_reg == ubx_pkg::PH_CLASS) ? 8'd0 : sum_b_reg;
        sum_a_add  = sum_a_base + rx_byte;
        sum_b_add  = sum_b_base + sum_a_add;
    end

    assign byte_count_inc = byte_count_reg + 8'd1;
    assign length_full    = {rx_byte, held_length_reg[7:0]};

    // Next state and result for the byte in hand
    always_comb
    begin
        phase_next       = phase_reg;
        sync_seen_next   = sync_seen_reg;
        byte_count_next  = byte_count_reg;
        held_class_next  = held_class_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        first_check_next = first_check_reg;

        result.payload_valid   = 1'b0;
        result.payload_byte    = 8'd0;
        result.payload_index   = 8'd0;
        result.frame_done      = 1'b0;
        result.checksum_ok     = 1'b0;
        result.length_too_long = 1'b0;

        unique case (phase_reg)
            ubx_pkg::PH_HUNT:
            begin
                // a wrong second byte drops the pair without re-testing it
                if (sync_seen_reg)
                begin
                    sync_seen_next = 1'b0;
                    if (rx_byte == ubx_pkg::SYNC_SECOND)
                    begin
                        phase_next = ubx_pkg::PH_CLASS;
                    end
                end
                else if (rx_byte == ubx_pkg::SYNC_FIRST)
                begin
                    sync_seen_next = 1'b1;
                end
            end
            ubx_pkg::PH_CLASS:
            begin
                held_class_next = rx_byte;
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
                phase_next      = ubx_pkg::PH_ID;
            end
            ubx_pkg::PH_ID:
            begin
                held_id_next = rx_byte;
                sum_a_next   = sum_a_add;
                sum_b_next   = sum_b_add;
                phase_next   = ubx_pkg::PH_LEN_LO;
            end
            ubx_pkg::PH_LEN_LO:
            begin
                held_length_next = {8'd0, rx_byte};
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_add;
                phase_next       = ubx_pkg::PH_LEN_HI;
            end
            ubx_pkg::PH_LEN_HI:
            begin
                // a zero length skips straight to the checksum
                held_length_next = length_full;
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_add;
                byte_count_next  = 8'd0;
                phase_next       = (length_full == 16'd0) ? ubx_pkg::PH_CK_A
                                                          : ubx_pkg::PH_PAYLOAD;
            end
            ubx_pkg::PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = byte_count_reg;
                sum_a_next           = sum_a_add;
                sum_b_next           = sum_b_add;
                byte_count_next      = byte_count_inc;
                // stop at the declared length or at the payload limit
                if (({8'd0, byte_count_inc} == held_length_reg)
                    || (byte_count_inc >= 8'(MAX_PAYLOAD)))
                begin
                    phase_next = ubx_pkg::PH_CK_A;
                end
            end
            ubx_pkg::PH_CK_A:
            begin
                first_check_next = rx_byte;
                phase_next       = ubx_pkg::PH_CK_B;
            end
            ubx_pkg::PH_CK_B:
            begin
                result.frame_done      = 1'b1;
                result.checksum_ok     = (first_check_reg == sum_a_reg)
                                         && (rx_byte == sum_b_reg);
                result.length_too_long = held_length_reg > 16'(MAX_PAYLOAD);
                phase_next             = ubx_pkg::PH_HUNT;
                sync_seen_next         = 1'b0;
            end
            default:
            begin
                phase_next     = ubx_pkg::PH_HUNT;
                sync_seen_next = 1'b0;
            end
        endcase

        result.msg_class  = held_class_next;
        result.msg_id     = held_id_next;
        result.msg_length = held_length_next;
    end

    // Advance the parser on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ubx_pkg::PH_HUNT;
            sync_seen_reg   <= 1'b0;
            byte_count_reg  <= 8'd0;
            held_class_reg  <= 8'd0;
            held_id_reg     <= 8'd0;
            held_length_reg <= 16'd0;
            sum_a_reg       <= 8'd0;
            sum_b_reg       <= 8'd0;
            first_check_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            sync_seen_reg   <= sync_seen_next;
            byte_count_reg  <= byte_count_next;
            held_class_reg  <= held_class_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            first_check_reg <= first_check_next;
        end
    end

endmodule

`default_nettype wire

[design/ubx_out_stage.sv]
// Result register with stream handshake towards the consumer.
// Depends on ubx_pkg.
`default_nettype none

module ubx_out_stage
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire ubx_pkg::ubx_result_t          result,
    output logic                               ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ubx_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic                 valid_reg, valid_next;
    ubx_pkg::ubx_result_t data_reg;

    // Take a new request whenever the register is empty or being drained
    assign ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.payload_valid;
    assign m_tlast  = data_reg.frame_done;
    assign m_tdata  = {6'd0,
                       data_reg.length_too_long,
                       data_reg.checksum_ok,
                       data_reg.msg_length,
                       data_reg.msg_id,
                       data_reg.msg_class,
                       data_reg.payload_index,
                       data_reg.payload_byte};

endmodule

`default_nettype wire

[design/ubx_frame_receiver.sv]
// UBX frame receiver: one received byte in, one result out per byte.
// A result is registered and presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while s_tready is high.
// s_tready drops only while the result register is full and not being taken.
// Reset (rst_n low, asynchronous): hunting for sync, held fields and sums zero.
`default_nettype none

module ubx_frame_receiver
#(
    parameter int MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] msg_class,
    // [31:24] msg_id, [47:32] msg_length, [48] checksum_ok,
    // [49] length_too_long, [55:50] zero
    output logic [ubx_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser,   // [0] payload_valid
    output logic                               m_tlast    // frame_done
);

    logic                 accept;
    ubx_pkg::ubx_result_t result;

    assign accept = s_tvalid && s_tready;

    ubx_parser
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .result  (result)
    );

    ubx_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[design/ubx_frame_receiver_checker.sv]
// Port-level checks of the UBX frame receiver, bound to the top level.
// Depends on ubx_pkg and ubx_frame_receiver_defines.svh.
`default_nettype none
`include "ubx_frame_receiver_defines.svh"

module ubx_frame_receiver_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [7:0]                    s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ubx_pkg::TDATA_W-1:0]   m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);

    logic unused_in;

    assign unused_in = s_tvalid ^ (^s_tdata);

    // A stalled result request holds
    `UBX_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An empty result register never blocks the input
    `UBX_ASSERT_SAME(a_ready, clk, rst_n, !m_tvalid, s_tready)

    // A payload byte never closes a frame
    `UBX_ASSERT_SAME(a_excl, clk, rst_n, m_tvalid && m_tuser, !m_tlast)

    // Frame flags are clear away from the end of a frame
    `UBX_ASSERT_SAME(a_flags, clk, rst_n, m_tvalid && !m_tlast, m_tdata[49:48] == 2'b00)

    // Payload fields are zero unless a payload byte is carried
    `UBX_ASSERT_SAME(a_pzero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[15:0] == 16'd0)

endmodule

bind ubx_frame_receiver ubx_frame_receiver_checker u_checker (.*);

`default_nettype wire
